// ===== src/tcct_pkg.sv =====
// Shared constants, types and field layout for the three-channel compare timer.
package tcct_pkg;

   localparam int CHANNELS   = 3;
   localparam int COUNT_BITS = 16;
   localparam int DATA_BITS  = 32;
   localparam int ADDR_BITS  = 6;
   localparam int REG_BITS   = 4;
   localparam int CH_BITS    = ADDR_BITS - REG_BITS;
   localparam int STAT_BITS  = 5;

   // stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W = ((ADDR_BITS + DATA_BITS + CH_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((DATA_BITS + CHANNELS + 7) / 8) * 8;

   typedef enum logic [1:0] {
      FUNC_READ  = 2'd0,
      FUNC_WRITE = 2'd1,
      FUNC_TICK  = 2'd2
   } func_type;

   typedef enum logic [REG_BITS-1:0] {
      REG_CTRL    = 4'd0,
      REG_MODE    = 4'd1,
      REG_COUNT   = 4'd4,
      REG_CMP_A   = 4'd5,
      REG_CMP_B   = 4'd6,
      REG_CMP_C   = 4'd7,
      REG_STATUS  = 4'd8,
      REG_IRQ_EN  = 4'd9,
      REG_IRQ_DIS = 4'd10,
      REG_IRQ_MSK = 4'd11
   } reg_type;

   localparam logic [DATA_BITS-1:0] MODE_WAVE   = 32'h0000_8000;
   localparam logic [DATA_BITS-1:0] MODE_RCTRIG = 32'h0000_4000;

   localparam logic [STAT_BITS-1:0] ST_A = 5'h04;
   localparam logic [STAT_BITS-1:0] ST_B = 5'h08;
   localparam logic [STAT_BITS-1:0] ST_C = 5'h10;

   // control register command bits
   localparam logic [1:0] CTRL_START = 2'b01;
   localparam int         CTRL_STOP_BIT = 1;

endpackage

// ===== src/three_channel_compare_timer_core.sv =====
// Three-channel compare timer: stream front end, per-channel state and result register.
// A transaction accepted on req_ passes through the input stage register and then the
//   result register before its result shows on rsp_.
// Throughput: one transaction per cycle while rsp_tready is high; all work is compares
//   and register updates done in a single pass from the input stage to the result register.
// Reset (synchronous, active high) empties both stages, zeroes all channel
//   registers, stops every counter and drops every interrupt line.
module three_channel_compare_timer_core
   import tcct_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // address[5:0], write_data[37:6], tick_channel[39:38]
   input  logic [1:0]            req_tuser,  // func[1:0]
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // read_data[31:0], irq_lines[34:32], zero pad
);

   // ------------------------------------------------------------------
   // input stage register
   // ------------------------------------------------------------------
   logic                  stage_valid_ff, stage_valid_in;
   logic [1:0]            stage_func_ff;
   logic [ADDR_BITS-1:0]  stage_addr_ff;
   logic [DATA_BITS-1:0]  stage_wdata_ff;
   logic [CH_BITS-1:0]    stage_tch_ff;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_BITS-1:0]  rsp_rdata_ff, rsp_rdata_in;
   logic [CHANNELS-1:0]   rsp_irq_ff;

   logic stage_fire;   // stage transaction is processed this cycle
   logic req_fire;

   // stage moves on when the result register is empty or being drained
   assign stage_fire = stage_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !stage_valid_ff || stage_fire;
   assign req_fire   = req_tvalid && req_tready;

   assign stage_valid_in = req_fire || (stage_valid_ff && !stage_fire);
   assign rsp_valid_in   = stage_fire || (rsp_valid_ff && !rsp_tready);

   // ------------------------------------------------------------------
   // per-channel state
   // ------------------------------------------------------------------
   logic [DATA_BITS-1:0]  mode_ff    [CHANNELS], mode_in    [CHANNELS];
   logic [COUNT_BITS-1:0] count_ff   [CHANNELS], count_in   [CHANNELS];
   logic [COUNT_BITS-1:0] cmp_a_ff   [CHANNELS], cmp_a_in   [CHANNELS];
   logic [COUNT_BITS-1:0] cmp_b_ff   [CHANNELS], cmp_b_in   [CHANNELS];
   logic [COUNT_BITS-1:0] cmp_c_ff   [CHANNELS], cmp_c_in   [CHANNELS];
   logic [STAT_BITS-1:0]  status_ff  [CHANNELS], status_in  [CHANNELS];
   logic [DATA_BITS-1:0]  mask_ff    [CHANNELS], mask_in    [CHANNELS];
   logic [CHANNELS-1:0]   run_ff, run_in;
   logic [CHANNELS-1:0]   irq_ff, irq_in;

   // decode of the staged transaction
   logic [CH_BITS-1:0]  bus_ch;
   logic [REG_BITS-1:0] bus_reg;
   logic                bus_ch_ok;
   logic                tick_ch_ok;

   assign bus_ch     = stage_addr_ff[ADDR_BITS-1:REG_BITS];
   assign bus_reg    = stage_addr_ff[REG_BITS-1:0];
   assign bus_ch_ok  = {1'b0, bus_ch} < (CH_BITS+1)'(CHANNELS);
   assign tick_ch_ok = {1'b0, stage_tch_ff} < (CH_BITS+1)'(CHANNELS);

   always_comb begin
      logic                  is_rd, is_wr, is_tk;
      logic [COUNT_BITS-1:0] cnt_inc;
      logic [STAT_BITS-1:0]  st_new;

      rsp_rdata_in = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         mode_in[i]   = mode_ff[i];
         count_in[i]  = count_ff[i];
         cmp_a_in[i]  = cmp_a_ff[i];
         cmp_b_in[i]  = cmp_b_ff[i];
         cmp_c_in[i]  = cmp_c_ff[i];
         status_in[i] = status_ff[i];
         mask_in[i]   = mask_ff[i];
         run_in[i]    = run_ff[i];
         irq_in[i]    = irq_ff[i];

         is_rd = stage_fire && (stage_func_ff == FUNC_READ) && bus_ch_ok
                 && (bus_ch == CH_BITS'(i));
         is_wr = stage_fire && (stage_func_ff == FUNC_WRITE) && bus_ch_ok
                 && (bus_ch == CH_BITS'(i));
         is_tk = stage_fire && (stage_func_ff == FUNC_TICK) && tick_ch_ok
                 && (stage_tch_ff == CH_BITS'(i)) && run_ff[i];

         cnt_inc = count_ff[i] + COUNT_BITS'(1);
         st_new  = status_ff[i];

         // bus read; status read is destructive and drops the line
         if (is_rd) begin
            case (bus_reg)
               REG_MODE:    rsp_rdata_in = mode_ff[i];
               REG_COUNT:   rsp_rdata_in = DATA_BITS'(count_ff[i]);
               REG_CMP_A:   rsp_rdata_in = DATA_BITS'(cmp_a_ff[i]);
               REG_CMP_B:   rsp_rdata_in = DATA_BITS'(cmp_b_ff[i]);
               REG_CMP_C:   rsp_rdata_in = DATA_BITS'(cmp_c_ff[i]);
               REG_STATUS: begin
                  rsp_rdata_in = DATA_BITS'(status_ff[i]);
                  status_in[i] = '0;
                  irq_in[i]    = 1'b0;
               end
               REG_IRQ_MSK: rsp_rdata_in = mask_ff[i];
               default:     rsp_rdata_in = '0;
            endcase
         end

         // bus write; counter register is read-only
         if (is_wr) begin
            case (bus_reg)
               REG_CTRL: begin
                  if (stage_wdata_ff[1:0] == CTRL_START) begin
                     count_in[i] = '0;
                     run_in[i]   = 1'b1;
                  end else if (stage_wdata_ff[CTRL_STOP_BIT]) begin
                     run_in[i]   = 1'b0;
                  end
               end
               REG_MODE:    mode_in[i]  = stage_wdata_ff;
               REG_CMP_A:   cmp_a_in[i] = stage_wdata_ff[COUNT_BITS-1:0];
               REG_CMP_B:   cmp_b_in[i] = stage_wdata_ff[COUNT_BITS-1:0];
               REG_CMP_C:   cmp_c_in[i] = stage_wdata_ff[COUNT_BITS-1:0];
               REG_IRQ_EN:  mask_in[i]  = mask_ff[i] | stage_wdata_ff;
               REG_IRQ_DIS: mask_in[i]  = mask_ff[i] & ~stage_wdata_ff;
               default:     ;
            endcase
         end

         // counter tick on a running channel
         if (is_tk) begin
            if ((mode_ff[i] & MODE_WAVE) != '0) begin
               count_in[i] = cnt_inc;
               if (cnt_inc == cmp_a_ff[i]) st_new = st_new | ST_A;
               if (cnt_inc == cmp_b_ff[i]) st_new = st_new | ST_B;
               if (cnt_inc == cmp_c_ff[i]) begin
                  st_new = st_new | ST_C;
                  if ((mode_ff[i] & MODE_RCTRIG) != '0) count_in[i] = '0;
               end
            end else begin
               // capture mode: one tick is a whole C period
               st_new      = st_new | ST_C;
               count_in[i] = ((mode_ff[i] & MODE_RCTRIG) != '0) ? '0 : cmp_c_ff[i];
            end
            status_in[i] = st_new;
            if ((st_new & mask_ff[i][STAT_BITS-1:0]) != '0) irq_in[i] = 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         run_ff         <= '0;
         irq_ff         <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            mode_ff[i]   <= '0;
            count_ff[i]  <= '0;
            cmp_a_ff[i]  <= '0;
            cmp_b_ff[i]  <= '0;
            cmp_c_ff[i]  <= '0;
            status_ff[i] <= '0;
            mask_ff[i]   <= '0;
         end
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         run_ff         <= run_in;
         irq_ff         <= irq_in;
         for (int i = 0; i < CHANNELS; i++) begin
            mode_ff[i]   <= mode_in[i];
            count_ff[i]  <= count_in[i];
            cmp_a_ff[i]  <= cmp_a_in[i];
            cmp_b_ff[i]  <= cmp_b_in[i];
            cmp_c_ff[i]  <= cmp_c_in[i];
            status_ff[i] <= status_in[i];
            mask_ff[i]   <= mask_in[i];
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_func_ff  <= req_tuser;
         stage_addr_ff  <= req_tdata[ADDR_BITS-1:0];
         stage_wdata_ff <= req_tdata[ADDR_BITS +: DATA_BITS];
         stage_tch_ff   <= req_tdata[ADDR_BITS+DATA_BITS +: CH_BITS];
      end
      if (stage_fire) begin
         rsp_rdata_ff <= rsp_rdata_in;
         rsp_irq_ff   <= irq_in;   // interrupt levels after this transaction
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_irq_ff, rsp_rdata_ff});

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   // output stage comes up empty after reset
   a_rsp_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // only a tick can raise an interrupt line
   a_irq_rise_on_tick_only: assert property (@(posedge clock) disable iff (reset)
      !(stage_fire && (stage_func_ff == FUNC_TICK)) |=> ((irq_ff & ~$past(irq_ff)) == '0))
      else $error("interrupt raised without a tick");

   // a status read leaves that channel's status cleared
   a_status_read_clears: assert property (@(posedge clock) disable iff (reset)
      stage_fire && (stage_func_ff == FUNC_READ) && bus_ch_ok && (bus_reg == REG_STATUS)
      |=> (status_ff[$past(bus_ch)] == '0) && !irq_ff[$past(bus_ch)])
      else $error("status read did not clear status");

   // stage register never drops a pending transaction
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !stage_fire |=> stage_valid_ff)
      else $error("staged transaction lost");

endmodule
